### sv/pmt_pkg.sv
package pmt_pkg;

  localparam int BANKS_PER_SET   = 8;
  localparam int BANK_W          = 3;
  localparam int OFF_W           = 13;
  localparam int LOC_W           = 23;
  localparam int CFG_W           = 10;
  localparam int PREFIX_W        = 2;
  localparam int RESET_PAGE_BASE = 56;

  localparam logic [15:0] VECTOR_LOW = 16'hFE00;
  localparam logic [15:0] PORT_LOW   = 16'hFF00;

  typedef enum logic [1:0] {
    FUNC_READ    = 2'd0,
    FUNC_WRITE   = 2'd1,
    FUNC_PAGE_WR = 2'd2,
    FUNC_MODE_WR = 2'd3
  } func_t;

  typedef enum logic [2:0] {
    TGT_RAM  = 3'd0,
    TGT_ROM  = 3'd1,
    TGT_CART = 3'd2,
    TGT_PORT = 3'd3,
    TGT_NONE = 3'd4
  } tgt_t;

  typedef enum logic [2:0] {
    REG_RAM_PAGE_MASK   = 3'd0,
    REG_TOP_PAGE        = 3'd1,
    REG_ROM_WINDOW_LOW  = 3'd2,
    REG_BANK_PREFIX     = 3'd3,
    REG_RESET_PAGE_BASE = 3'd4
  } cfg_reg_t;

endpackage

### sv/paged_mmu_translate.sv
// Paged address translator for 16-bit CPU byte accesses onto 8 KB pages.
// Input channel (in_valid/in_ready) carries one item: a read, a write, a page
// register write or a mode write. The result channel (out_valid/out_ready)
// returns exactly one item per input item, in order: target, location within
// the target, the write strobe and the byte to store. Register and mode
// writes return a result with target "nothing".
// An accepted item is held in an input register; its result is then loaded
// into the output register, from which it is offered. Both stages move
// together, and the block takes one item per cycle while the receiver keeps up.
// When out_ready is low, the result holds and the input register fills; once
// both are full, in_ready drops until the receiver takes the result.
// Reset loads every page register with its bank index plus the reset page
// base, clears the mode bits and loads the configuration registers with their
// defaults. The APB port sets the configuration registers; the user writes it
// only while no item is in flight, which the block itself does not enforce.
module paged_mmu_translate
  import pmt_pkg::*;
#(
  parameter int PAGE_BITS = 10
) (
  input  logic                clk,
  input  logic                rst_n,

  input  logic                in_valid,
  output logic                in_ready,
  input  logic [1:0]          in_func,
  input  logic [15:0]         in_cpu_address,
  input  logic [7:0]          in_data,
  input  logic [3:0]          in_reg_index,

  output logic                out_valid,
  input  logic                out_ready,
  output logic [2:0]          out_target,
  output logic [LOC_W-1:0]    out_location,
  output logic                out_is_write,
  output logic [7:0]          out_write_byte,

  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [4:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);

  localparam int PB = PAGE_BITS;

  logic [CFG_W-1:0]    ram_page_mask_r, top_page_r, rom_window_low_r, reset_page_base_r;
  logic [PREFIX_W-1:0] bank_prefix_r;

  logic       task_sel_r, mmu_on_r, all_ram_r, vectors_in_ram_r;
  logic [1:0] rom_map_mode_r;

  logic [PB-1:0] page_r [2*BANKS_PER_SET];

  logic        s1_valid_r;
  func_t       s1_func_r;
  logic [15:0] s1_addr_r;
  logic [7:0]  s1_data_r;
  logic [3:0]  s1_ridx_r;

  logic             out_valid_r;
  tgt_t             out_target_r;
  logic [LOC_W-1:0] out_location_r;
  logic             out_is_write_r;
  logic [7:0]       out_write_byte_r;

  logic advance;
  logic cfg_wr;

  logic [BANK_W-1:0] bank;
  logic [PB-1:0]     page;
  logic [PB-1:0]     top;
  logic [PB:0]       diff;
  logic              in_win;
  logic [1:0]        k;
  tgt_t              win_tgt;
  logic [1:0]        win_idx;
  tgt_t              dec_tgt;
  logic [LOC_W-1:0]  dec_loc;
  logic              wr_ok;
  logic              is_wr;
  logic [PB-1:0]     pg_wr_val;

  tgt_t             res_tgt;
  logic [LOC_W-1:0] res_loc;
  logic             res_wr;
  logic [7:0]       res_wb;

  assign advance  = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || advance;
  assign cfg_wr   = psel && penable && pwrite && pready;
  assign pready   = 1'b1;

  assign out_valid      = out_valid_r;
  assign out_target     = out_target_r;
  assign out_location   = out_location_r;
  assign out_is_write   = out_is_write_r;
  assign out_write_byte = out_write_byte_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ram_page_mask_r   <= CFG_W'(63);
      top_page_r        <= CFG_W'(63);
      rom_window_low_r  <= CFG_W'(60);
      bank_prefix_r     <= '0;
      reset_page_base_r <= CFG_W'(RESET_PAGE_BASE);
    end else if (cfg_wr) begin
      unique case (cfg_reg_t'(paddr[4:2]))
        REG_RAM_PAGE_MASK:   ram_page_mask_r   <= pwdata[CFG_W-1:0];
        REG_TOP_PAGE:        top_page_r        <= pwdata[CFG_W-1:0];
        REG_ROM_WINDOW_LOW:  rom_window_low_r  <= pwdata[CFG_W-1:0];
        REG_BANK_PREFIX:     bank_prefix_r     <= pwdata[PREFIX_W-1:0];
        REG_RESET_PAGE_BASE: reset_page_base_r <= pwdata[CFG_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (cfg_reg_t'(paddr[4:2]))
      REG_RAM_PAGE_MASK:   prdata = 32'(ram_page_mask_r);
      REG_TOP_PAGE:        prdata = 32'(top_page_r);
      REG_ROM_WINDOW_LOW:  prdata = 32'(rom_window_low_r);
      REG_BANK_PREFIX:     prdata = 32'(bank_prefix_r);
      REG_RESET_PAGE_BASE: prdata = 32'(reset_page_base_r);
      default:             prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_func_r <= func_t'(in_func);
      s1_addr_r <= in_cpu_address;
      s1_data_r <= in_data;
      s1_ridx_r <= in_reg_index;
    end
  end

  assign pg_wr_val = PB'(({bank_prefix_r, 8'h00}) | ({2'b00, s1_data_r} & ram_page_mask_r));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 2*BANKS_PER_SET; i++) begin
        page_r[i] <= PB'((i % BANKS_PER_SET) + RESET_PAGE_BASE);
      end
    end else if (advance && s1_func_r == FUNC_PAGE_WR) begin
      page_r[s1_ridx_r] <= pg_wr_val;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      task_sel_r       <= 1'b0;
      mmu_on_r         <= 1'b0;
      rom_map_mode_r   <= 2'b00;
      all_ram_r        <= 1'b0;
      vectors_in_ram_r <= 1'b0;
    end else if (advance && s1_func_r == FUNC_MODE_WR) begin
      task_sel_r       <= s1_data_r[0];
      mmu_on_r         <= s1_data_r[1];
      rom_map_mode_r   <= s1_data_r[3:2];
      all_ram_r        <= s1_data_r[4];
      vectors_in_ram_r <= s1_data_r[5];
    end
  end

  assign bank   = s1_addr_r[15:13];
  assign page   = mmu_on_r ? page_r[{task_sel_r, bank}]
                           : PB'(32'(bank) + RESET_PAGE_BASE);
  assign top    = top_page_r[PB-1:0];
  assign diff   = {1'b0, top} - {1'b0, page};
  assign in_win = !diff[PB] && (diff[PB-1:2] == '0);
  assign k      = diff[1:0];
  assign wr_ok  = all_ram_r || (page < rom_window_low_r[PB-1:0]) || (page > top);
  assign is_wr  = (s1_func_r == FUNC_WRITE);

  always_comb begin
    unique case (rom_map_mode_r)
      2'd2: begin
        win_tgt = TGT_ROM;
        win_idx = ~k;
      end
      2'd3: begin
        win_tgt = TGT_CART;
        win_idx = {k[1], ~k[0]};
      end
      default: begin
        win_tgt = k[1] ? TGT_ROM : TGT_CART;
        win_idx = {1'b0, ~k[0]};
      end
    endcase
  end

  always_comb begin
    priority if (in_win && !all_ram_r) begin
      dec_tgt = win_tgt;
      dec_loc = LOC_W'({win_idx, s1_addr_r[OFF_W-1:0]});
    end else if (in_win) begin
      dec_tgt = TGT_RAM;
      dec_loc = LOC_W'({page, s1_addr_r[OFF_W-1:0]});
    end else begin
      dec_tgt = TGT_RAM;
      dec_loc = LOC_W'({page & ram_page_mask_r[PB-1:0], s1_addr_r[OFF_W-1:0]});
    end
  end

  always_comb begin
    res_tgt = TGT_NONE;
    res_loc = '0;
    res_wr  = 1'b0;
    res_wb  = '0;
    if (s1_func_r == FUNC_READ || s1_func_r == FUNC_WRITE) begin
      priority if (s1_addr_r >= PORT_LOW) begin
        res_tgt = TGT_PORT;
        res_loc = LOC_W'(s1_addr_r);
      end else if (s1_addr_r >= VECTOR_LOW && vectors_in_ram_r) begin
        res_tgt = TGT_RAM;
        res_loc = LOC_W'({top, s1_addr_r[OFF_W-1:0]});
      end else if (is_wr && (!wr_ok || dec_tgt != TGT_RAM)) begin
        res_tgt = TGT_NONE;
        res_loc = '0;
      end else begin
        res_tgt = dec_tgt;
        res_loc = dec_loc;
      end
      if (is_wr && res_tgt != TGT_NONE) begin
        res_wr = 1'b1;
        res_wb = s1_data_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_target_r     <= res_tgt;
      out_location_r   <= res_loc;
      out_is_write_r   <= res_wr;
      out_write_byte_r <= res_wb;
    end
  end

endmodule

### bench/tb_paged_mmu_translate.sv
`timescale 1ns / 1ps

module tb_paged_mmu_translate;
  import pmt_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int LONG_HOLD_AT = 250;
  localparam int LONG_HOLD_LEN = 64;
  localparam int PHASE_ITEMS = 147;
  localparam logic [1:0] MAP_ALL_ROM = 2'd2;
  localparam logic [1:0] MAP_ALL_CART = 2'd3;

  typedef struct packed {
    func_t       func;
    logic [15:0] addr;
    logic [7:0]  data;
    logic [3:0]  ridx;
  } mmu_req_t;

  typedef struct packed {
    tgt_t             target;
    logic [LOC_W-1:0] location;
    logic             is_write;
    logic [7:0]       write_byte;
  } mmu_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic        in_valid = 1'b0;
  wire         in_ready;
  logic [1:0]  in_func = '0;
  logic [15:0] in_cpu_address = '0;
  logic [7:0]  in_data = '0;
  logic [3:0]  in_reg_index = '0;

  wire             out_valid;
  logic            out_ready = 1'b0;
  wire [2:0]       out_target;
  wire [LOC_W-1:0] out_location;
  wire             out_is_write;
  wire [7:0]       out_write_byte;

  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [4:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  wire  [31:0] prdata;
  wire         pready;

  paged_mmu_translate u_top (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_func       (in_func),
    .in_cpu_address(in_cpu_address),
    .in_data       (in_data),
    .in_reg_index  (in_reg_index),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_target    (out_target),
    .out_location  (out_location),
    .out_is_write  (out_is_write),
    .out_write_byte(out_write_byte),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  // Shadow copy of the translator's registers.
  logic [9:0] page_tbl [32];
  logic [9:0] cfg_ram_mask = 10'd63;
  logic [9:0] cfg_top = 10'd63;
  logic [9:0] cfg_rom_low = 10'd60;
  logic [1:0] cfg_prefix = 2'd0;
  logic [9:0] cfg_reset_base = 10'(RESET_PAGE_BASE);
  logic       mode_task = 1'b0;
  logic       mode_mmu_on = 1'b0;
  logic [1:0] mode_rom_map = 2'd0;
  logic       mode_all_ram = 1'b0;
  logic       mode_vec_ram = 1'b0;

  mmu_req_t    pending_accesses [$];
  mmu_result_t expected_translations [$];
  mmu_req_t    cur_req;
  mmu_result_t expected_now;

  bit idle_on = 1'b1;
  int send_gap = 0;
  int stall_left = 0;
  int long_hold = 0;
  bit long_hold_done = 1'b0;
  int results_done = 0;
  int fail_count = 0;
  int cycle_count = 0;

  function automatic mmu_result_t translate_access(input mmu_req_t rq);
    mmu_result_t r;
    logic [9:0]  pg;
    logic [9:0]  gap_to_top;
    logic [1:0]  slot;
    logic [12:0] off;
    logic        allowed;
    r.target = TGT_NONE;
    r.location = '0;
    r.is_write = 1'b0;
    r.write_byte = '0;
    off = rq.addr[12:0];
    case (rq.func)
      FUNC_PAGE_WR: page_tbl[{1'b0, rq.ridx}] = {cfg_prefix, rq.data & cfg_ram_mask[7:0]};
      FUNC_MODE_WR: begin
        mode_task = rq.data[0];
        mode_mmu_on = rq.data[1];
        mode_rom_map = rq.data[3:2];
        mode_all_ram = rq.data[4];
        mode_vec_ram = rq.data[5];
      end
      default: begin
        if (rq.addr >= PORT_LOW) begin
          r.target = TGT_PORT;
          r.location = LOC_W'(rq.addr);
        end else if (rq.addr >= VECTOR_LOW && mode_vec_ram) begin
          r.target = TGT_RAM;
          r.location = {cfg_top, off};
        end else begin
          pg = page_tbl[{~mode_mmu_on, mode_task, rq.addr[15:13]}];
          gap_to_top = cfg_top - pg;
          if (pg <= cfg_top && gap_to_top <= 10'd3 && !mode_all_ram) begin
            case (mode_rom_map)
              MAP_ALL_ROM: begin
                r.target = TGT_ROM;
                slot = 2'd3 - gap_to_top[1:0];
              end
              MAP_ALL_CART: begin
                r.target = TGT_CART;
                slot = gap_to_top[1:0] ^ 2'd1;
              end
              default: begin
                r.target = gap_to_top[1] ? TGT_ROM : TGT_CART;
                slot = {1'b0, ~gap_to_top[0]};
              end
            endcase
            r.location = {8'd0, slot, off};
          end else if (pg <= cfg_top && gap_to_top <= 10'd3) begin
            r.target = TGT_RAM;
            r.location = {pg, off};
          end else begin
            r.target = TGT_RAM;
            r.location = {pg & cfg_ram_mask, off};
          end
          if (rq.func == FUNC_WRITE) begin
            allowed = mode_all_ram || pg < cfg_rom_low || pg > cfg_top;
            if (!allowed || r.target != TGT_RAM) begin
              r.target = TGT_NONE;
              r.location = '0;
            end
          end
        end
        if (rq.func == FUNC_WRITE && r.target != TGT_NONE) begin
          r.is_write = 1'b1;
          r.write_byte = rq.data;
        end
      end
    endcase
    return r;
  endfunction

  initial begin
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        expected_translations.push_back(translate_access(cur_req));
      end
      if (!in_valid || in_ready) begin
        if (send_gap > 0) begin
          send_gap--;
          in_valid <= 1'b0;
        end else if (idle_on && pending_accesses.size() > 0 && $urandom_range(0, 5) == 0) begin
          send_gap = $urandom_range(0, 3);
          in_valid <= 1'b0;
        end else if (pending_accesses.size() > 0) begin
          cur_req = pending_accesses.pop_front();
          in_valid <= 1'b1;
          in_func <= cur_req.func;
          in_cpu_address <= cur_req.addr;
          in_data <= cur_req.data;
          in_reg_index <= cur_req.ridx;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_translations.size() == 0) begin
          $error("unexpected result item: target %0d location %0h", out_target, out_location);
          fail_count++;
        end else begin
          expected_now = expected_translations.pop_front();
          if (out_target !== expected_now.target) begin
            $error("target: expected %0d, actual %0d", expected_now.target, out_target);
            fail_count++;
          end
          if (out_location !== expected_now.location) begin
            $error("location: expected %0h, actual %0h", expected_now.location, out_location);
            fail_count++;
          end
          if (out_is_write !== expected_now.is_write) begin
            $error("is_write: expected %0d, actual %0d", expected_now.is_write, out_is_write);
            fail_count++;
          end
          if (out_write_byte !== expected_now.write_byte) begin
            $error("write_byte: expected %0h, actual %0h", expected_now.write_byte,
                   out_write_byte);
            fail_count++;
          end
        end
        results_done++;
      end
      if (long_hold > 0) begin
        long_hold--;
        out_ready <= 1'b0;
      end else if (results_done >= LONG_HOLD_AT && !long_hold_done) begin
        long_hold_done = 1'b1;
        long_hold = LONG_HOLD_LEN - 1;
        out_ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else if (idle_on && $urandom_range(0, 6) == 0) begin
        stall_left = $urandom_range(0, 3);
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  task automatic cfg_write(input cfg_reg_t idx, input logic [31:0] value);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      REG_RAM_PAGE_MASK:   cfg_ram_mask = value[9:0];
      REG_TOP_PAGE:        cfg_top = value[9:0];
      REG_ROM_WINDOW_LOW:  cfg_rom_low = value[9:0];
      REG_BANK_PREFIX:     cfg_prefix = value[1:0];
      REG_RESET_PAGE_BASE: cfg_reset_base = value[9:0];
      default: ;
    endcase
  endtask

  task automatic set_config(input logic [9:0] mask, input logic [9:0] top,
                            input logic [9:0] low, input logic [1:0] prefix,
                            input logic [9:0] base);
    cfg_write(REG_RAM_PAGE_MASK, 32'(mask));
    cfg_write(REG_TOP_PAGE, 32'(top));
    cfg_write(REG_ROM_WINDOW_LOW, 32'(low));
    cfg_write(REG_BANK_PREFIX, 32'(prefix));
    cfg_write(REG_RESET_PAGE_BASE, 32'(base));
    repeat (2) @(negedge clk);
  endtask

  task automatic queue_req(input func_t f, input logic [15:0] a, input logic [7:0] d,
                           input logic [3:0] r);
    mmu_req_t rq;
    rq.func = f;
    rq.addr = a;
    rq.data = d;
    rq.ridx = r;
    pending_accesses.push_back(rq);
  endtask

  function automatic logic [15:0] pick_address();
    case ($urandom_range(0, 9))
      0, 1: return {8'hFE, 8'($urandom)};
      2: return {8'hFF, 8'($urandom)};
      3: return {3'($urandom), ($urandom_range(0, 1) ? 13'h1FFF : 13'h0000)};
      default: return 16'($urandom);
    endcase
  endfunction

  // Page values near the top page reach the ROM window, some near rom_low.
  function automatic logic [7:0] pick_page_data();
    case ($urandom_range(0, 4))
      0, 1: return cfg_top[7:0] - 8'($urandom_range(0, 4));
      2: return cfg_rom_low[7:0] - 8'($urandom_range(0, 1));
      default: return 8'($urandom);
    endcase
  endfunction

  task automatic wait_drained();
    do @(negedge clk);
    while (pending_accesses.size() != 0 || in_valid || expected_translations.size() != 0);
    repeat (4) @(negedge clk);
  endtask

  // Mostly a mode byte, a few page register writes into the selected set and a
  // run of accesses; the rest is loose noise.
  task automatic random_phase(input int n_items, input bit idle);
    logic [7:0] mode;
    idle_on = idle;
    while (pending_accesses.size() < n_items) begin
      if ($urandom_range(0, 4) == 0) begin
        queue_req(func_t'($urandom_range(0, 3)), pick_address(), pick_page_data(),
                  4'($urandom));
      end else begin
        mode = 8'($urandom);
        mode[4] = ($urandom_range(0, 3) == 0);
        queue_req(FUNC_MODE_WR, 16'($urandom), mode, 4'($urandom));
        repeat ($urandom_range(1, 3)) begin
          queue_req(FUNC_PAGE_WR, 16'($urandom), pick_page_data(),
                    {mode[0], 3'($urandom)});
        end
        repeat ($urandom_range(3, 8)) begin
          queue_req(func_t'($urandom_range(0, 1)), pick_address(), 8'($urandom),
                    4'($urandom));
        end
      end
    end
    wait_drained();
  endtask

  initial begin
    logic [9:0] r_top;
    logic [9:0] r_low;
    for (int i = 0; i < 32; i++) begin
      page_tbl[i] = 10'((i % BANKS_PER_SET) + RESET_PAGE_BASE);
    end
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    repeat (2) @(negedge clk);

    queue_req(FUNC_READ, 16'h0000, 8'h00, 4'h0);
    queue_req(FUNC_READ, 16'h8000, 8'h00, 4'h0);
    queue_req(FUNC_READ, 16'hA000, 8'h00, 4'h0);
    queue_req(FUNC_READ, 16'hC000, 8'h00, 4'h0);
    queue_req(FUNC_READ, 16'hFDFF, 8'h00, 4'h0);
    queue_req(FUNC_WRITE, 16'h8000, 8'hAA, 4'h0);
    queue_req(FUNC_WRITE, 16'h1FFF, 8'hFF, 4'hF);
    queue_req(FUNC_READ, 16'hFE00, 8'h00, 4'h0);
    queue_req(FUNC_WRITE, 16'hFEFF, 8'h55, 4'h0);
    queue_req(FUNC_WRITE, 16'hFF00, 8'h01, 4'h0);
    queue_req(FUNC_READ, 16'hFFFF, 8'h00, 4'h0);
    queue_req(FUNC_MODE_WR, 16'h0000, 8'h28, 4'h0);
    queue_req(FUNC_READ, 16'hC000, 8'h00, 4'h0);
    queue_req(FUNC_WRITE, 16'hFE10, 8'hC3, 4'h0);
    queue_req(FUNC_MODE_WR, 16'h0000, 8'h0C, 4'h0);
    queue_req(FUNC_READ, 16'h8000, 8'h00, 4'h0);
    queue_req(FUNC_READ, 16'hE000, 8'h00, 4'h0);
    queue_req(FUNC_MODE_WR, 16'hFFFF, 8'hD3, 4'h0);
    queue_req(FUNC_PAGE_WR, 16'h0000, 8'hFF, 4'hF);
    queue_req(FUNC_READ, 16'hE000, 8'h00, 4'h0);
    queue_req(FUNC_WRITE, 16'hE123, 8'h5A, 4'h0);
    queue_req(FUNC_PAGE_WR, 16'h0000, 8'h00, 4'h8);
    queue_req(FUNC_MODE_WR, 16'h0000, 8'h03, 4'h0);
    queue_req(FUNC_WRITE, 16'h0000, 8'h7E, 4'h0);
    queue_req(FUNC_READ, 16'hE000, 8'h00, 4'h0);
    wait_drained();

    random_phase(PHASE_ITEMS, 1'b1);
    set_config(10'd1023, 10'd1023, 10'd1020, 2'd3, 10'd1023);
    random_phase(PHASE_ITEMS, 1'b1);
    set_config(10'd0, 10'd0, 10'd0, 2'd0, 10'd0);
    random_phase(PHASE_ITEMS, 1'b0);
    set_config(10'd255, 10'd2, 10'd1, 2'd0, 10'd5);
    random_phase(PHASE_ITEMS, 1'b1);
    repeat (2) begin
      r_top = 10'($urandom_range(0, 1023));
      r_low = (r_top > 10'd8) ? r_top - 10'($urandom_range(0, 8)) : 10'd0;
      set_config(10'($urandom_range(0, 1023)), r_top, r_low,
                 $urandom_range(0, 1) ? r_top[9:8] : 2'($urandom),
                 10'($urandom_range(0, 1023)));
      random_phase(PHASE_ITEMS, 1'b1);
    end
    set_config(10'd63, 10'd63, 10'd60, 2'd0, 10'd56);
    random_phase(PHASE_ITEMS, 1'b0);

    repeat (8) @(negedge clk);
    if (fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
